[src/voice_allocator_oldest_steal_top_macros.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_TOP_MACROS_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define VAOS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vaos assertion failed");
`define VAOS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vaos assertion failed");
`else
`define VAOS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VAOS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[src/vaos_pkg.sv]
// ----------------------------------------------------------------------------
// Voice allocator package
// Types and constants shared by the voice allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vaos_pkg;

   localparam int MAX_VOICES = 16;
   localparam int VOICE_W    = 4;
   localparam int CNT_W      = $clog2(MAX_VOICES + 1);
   localparam int VC_W       = 5;

   localparam logic [VC_W-1:0] VOICE_COUNT_RESET = VC_W'(16);

   localparam logic MODE_NOTE_ON  = 1'b0;
   localparam logic MODE_FINISHED = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [VOICE_W-1:0] finished_voice;
   } req_payload_type;

   typedef struct packed {
      logic [VOICE_W-1:0] granted_voice;
      logic               was_stolen;
   } rsp_payload_type;

   typedef struct packed {
      logic [VOICE_W-1:0] rd_idx;
      logic               wr_en;
      logic [VOICE_W-1:0] wr_idx;
      logic [VOICE_W-1:0] wr_data;
      logic               cnt_dec;
      logic               cnt_inc;
   } list_ctl_type;

   typedef struct packed {
      logic [VOICE_W-1:0] rd_data;
      logic [CNT_W-1:0]   count;
   } list_sts_type;

endpackage

`default_nettype wire

[src/vaos_list.sv]
// ----------------------------------------------------------------------------
// Voice allocator age list
// Oldest-first list of active voices: one read, one write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "voice_allocator_oldest_steal_top_macros.svh"

module vaos_list import vaos_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire list_ctl_type ctl,
   output list_sts_type      sts
);

   logic [VOICE_W-1:0] order_ff [MAX_VOICES];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         order_ff[ctl.wr_idx] <= ctl.wr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign sts.rd_data = order_ff[ctl.rd_idx];
   assign sts.count   = count_ff;

   `VAOS_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_VOICES))
   `VAOS_ASSERT_IMP(a_dec_nonzero, clock, reset, ctl.cnt_dec, count_ff != '0)
   `VAOS_ASSERT_IMP(a_inc_room, clock, reset, ctl.cnt_inc,
                    count_ff != CNT_W'(MAX_VOICES))

endmodule

`default_nettype wire

[src/vaos_ctrl.sv]
// ----------------------------------------------------------------------------
// Voice allocator sequencer
// Scans busy bits one voice a cycle, compacts and appends the age list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "voice_allocator_oldest_steal_top_macros.svh"

module vaos_ctrl import vaos_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic [VC_W-1:0] voice_count,
   input  wire logic            res_free,
   output logic                 res_valid,
   output rsp_payload_type      res_payload,
   output list_ctl_type         list_ctl,
   input  wire list_sts_type    list_sts
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_SCAN    = 6'b000010,
      S_HEAD    = 6'b000100,
      S_COMPACT = 6'b001000,
      S_APPEND  = 6'b010000,
      S_RESULT  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [MAX_VOICES-1:0] busy_ff, busy_in;
   logic                 mode_ff, mode_in;
   logic [VOICE_W-1:0]   target_ff, target_in;
   logic [VOICE_W-1:0]   idx_ff, idx_in;
   logic [VOICE_W-1:0]   last_ff, last_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [VOICE_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic                 found_ff, found_in;
   logic [VOICE_W-1:0]   chosen_ff, chosen_in;
   logic                 stolen_ff, stolen_in;
   logic [VOICE_W-1:0]   last_eff;
   logic                 match;

   always_comb begin
      priority if (voice_count == '0) begin
         last_eff = '0;
      end else if (voice_count > VC_W'(MAX_VOICES)) begin
         last_eff = VOICE_W'(MAX_VOICES - 1);
      end else begin
         last_eff = VOICE_W'(voice_count - VC_W'(1));
      end
   end

   assign match     = (list_sts.rd_data == target_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESULT) && res_free;
   assign res_payload.granted_voice = chosen_ff;
   assign res_payload.was_stolen    = stolen_ff;

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      mode_in   = mode_ff;
      target_in = target_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      found_in  = found_ff;
      chosen_in = chosen_ff;
      stolen_in = stolen_ff;

      list_ctl.rd_idx  = rd_ptr_ff[VOICE_W-1:0];
      list_ctl.wr_en   = 1'b0;
      list_ctl.wr_idx  = wr_ptr_ff;
      list_ctl.wr_data = list_sts.rd_data;
      list_ctl.cnt_dec = 1'b0;
      list_ctl.cnt_inc = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_payload.mode;
               target_in = req_payload.finished_voice;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               found_in  = 1'b0;
               idx_in    = '0;
               last_in   = last_eff;
               if (req_payload.mode == MODE_FINISHED) begin
                  if (busy_ff[req_payload.finished_voice]) begin
                     busy_in[req_payload.finished_voice] = 1'b0;
                     state_in = S_COMPACT;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!busy_ff[idx_ff]) begin
               chosen_in = idx_ff;
               stolen_in = 1'b0;
               state_in  = S_APPEND;
            end else if (idx_ff == last_ff) begin
               state_in = S_HEAD;
            end else begin
               idx_in = idx_ff + VOICE_W'(1);
            end
         end
         S_HEAD: begin
            stolen_in = 1'b1;
            if (list_sts.count == '0) begin
               chosen_in = '0;
               state_in  = S_APPEND;
            end else begin
               chosen_in = list_sts.rd_data;
               target_in = list_sts.rd_data;
               state_in  = S_COMPACT;
            end
         end
         S_COMPACT: begin
            if (rd_ptr_ff == list_sts.count) begin
               list_ctl.cnt_dec = found_ff;
               state_in = (mode_ff == MODE_NOTE_ON) ? S_APPEND : S_IDLE;
            end else begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               if (match && !found_ff) begin
                  found_in = 1'b1;
               end else begin
                  list_ctl.wr_en = 1'b1;
                  wr_ptr_in = wr_ptr_ff + VOICE_W'(1);
               end
            end
         end
         S_APPEND: begin
            busy_in[chosen_ff] = 1'b1;
            list_ctl.wr_idx  = list_sts.count[VOICE_W-1:0];
            list_ctl.wr_data = chosen_ff;
            if (list_sts.count != CNT_W'(MAX_VOICES)) begin
               list_ctl.wr_en   = 1'b1;
               list_ctl.cnt_inc = 1'b1;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      target_ff <= target_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      found_ff  <= found_in;
      chosen_ff <= chosen_in;
      stolen_ff <= stolen_in;
   end

   `VAOS_ASSERT_IMP(a_busy_matches_list, clock, reset, state_ff == S_IDLE,
                    $countones(busy_ff) == list_sts.count)
   `VAOS_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == S_SCAN,
                    idx_ff <= last_ff)
   `VAOS_ASSERT_IMP(a_removed_found, clock, reset,
                    (state_ff == S_COMPACT) && (rd_ptr_ff == list_sts.count),
                    found_ff)

endmodule

`default_nettype wire

[src/voice_allocator_oldest_steal_top.sv]
// Sequencing: a note-on scans one busy bit a cycle, then on a steal compacts one age-list entry
//   a cycle (the age list holds at most 16 entries) before appending; a voice finished
//   compacts the age list when that voice was busy.
// Throughput: one word at a time, set by the shared scan and list sequencer; no new word
//   is taken until the previous one is done; a second result waits while the first is held.
// Reset: synchronous, active high; all voices idle, age list empty, voice count 16.
// ----------------------------------------------------------------------------
// Voice allocator top level
// Polyphonic voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voice_allocator_oldest_steal_top import vaos_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [VC_W-1:0] csr_data
);

   logic [VC_W-1:0] voice_count_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            res_free;
   logic            res_valid;
   rsp_payload_type res_payload;
   list_ctl_type    list_ctl;
   list_sts_type    list_sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= VOICE_COUNT_RESET;
      end else if (csr_valid) begin
         voice_count_ff <= csr_data;
      end
   end

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_payload;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   vaos_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .voice_count (voice_count_ff),
      .res_free    (res_free),
      .res_valid   (res_valid),
      .res_payload (res_payload),
      .list_ctl    (list_ctl),
      .list_sts    (list_sts)
   );

   vaos_list u_list (
      .clock (clock),
      .reset (reset),
      .ctl   (list_ctl),
      .sts   (list_sts)
   );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note-on and voice-finished words with random bursts and gaps. The
// result side stalls on its own pattern. A local model tracks the busy mask
// and the age-ordered voice list, and every granted voice is checked against
// it in order. The polyphony register is changed between phases, its extremes
// among the settings.
// ----------------------------------------------------------------------------

module tb;
   import vaos_pkg::*;

   localparam int SETTLE_CYCLES  = 40;
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLD_OFF       = 300;
   localparam int PHASE_WORDS    = 100;
   localparam int RANDOM_PHASES  = 8;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_payload_type     req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_payload_type     rsp_payload;
   logic                csr_valid;
   logic                csr_ready;
   logic [VC_W-1:0]     csr_data;

   logic [MAX_VOICES-1:0] voice_busy_mask;
   logic [VOICE_W-1:0]    age_list[$];
   logic [VC_W-1:0]       polyphony;
   rsp_payload_type       grant_queue[$];
   rsp_payload_type       oldest_grant;

   int  errors;
   int  idle_cycles;
   int  burst_left;
   bit  pacing_on;
   bit  stall_enable;
   int  hold_cycles;

   voice_allocator_oldest_steal_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void predict_event(input req_payload_type ev);
      int              n;
      int              slot;
      bit              found;
      rsp_payload_type grant;
      if (ev.mode == MODE_FINISHED) begin
         if (voice_busy_mask[ev.finished_voice]) begin
            voice_busy_mask[ev.finished_voice] = 1'b0;
            for (int i = 0; i < age_list.size(); i++) begin
               if (age_list[i] == ev.finished_voice) begin
                  age_list.delete(i);
                  break;
               end
            end
         end
         return;
      end
      n = (polyphony == 0) ? 1 : ((polyphony > MAX_VOICES) ? MAX_VOICES : int'(polyphony));
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!found && !voice_busy_mask[i]) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (!found && age_list.size() > 0) begin
         slot = int'(age_list[0]);
         age_list.delete(0);
      end
      voice_busy_mask[slot] = 1'b1;
      age_list.insert(age_list.size(), VOICE_W'(slot));
      grant.granted_voice = VOICE_W'(slot);
      grant.was_stolen    = !found;
      grant_queue.insert(grant_queue.size(), grant);
   endfunction

   task automatic send_event(input logic mode, input logic [VOICE_W-1:0] voice);
      req_payload_type ev;
      int              gap;
      ev.mode           = mode;
      ev.finished_voice = voice;
      if (pacing_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_event(ev);
   endtask

   task automatic note_on();
      send_event(MODE_NOTE_ON, VOICE_W'($urandom_range(0, MAX_VOICES - 1)));
   endtask

   task automatic voice_done(input int voice);
      send_event(MODE_FINISHED, VOICE_W'(voice));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_polyphony(input int count);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= VC_W'(count);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      polyphony = VC_W'(count);
      csr_valid <= 1'b0;
   endtask

   task automatic random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         note_on();
      else if (pick < 90 && age_list.size() > 0)
         voice_done(age_list[$urandom_range(0, age_list.size() - 1)]);
      else
         voice_done($urandom_range(0, MAX_VOICES - 1));
   endtask

   task automatic test_fill_and_steal();
      pacing_on    = 1'b0;
      stall_enable = 1'b0;
      repeat (MAX_VOICES + 1) note_on();
      settle();
   endtask

   task automatic test_finish_events();
      stall_enable = 1'b1;
      voice_done(MAX_VOICES - 1);
      voice_done(MAX_VOICES - 1);
      voice_done(0);
      note_on();
      note_on();
      settle();
   endtask

   task automatic test_count_limits();
      set_polyphony(0);
      note_on();
      note_on();
      set_polyphony(31);
      voice_done(7);
      note_on();
      note_on();
      set_polyphony(1);
      voice_done(10);
      note_on();
      voice_done(0);
      note_on();
      set_polyphony(17);
      note_on();
      settle();
   endtask

   task automatic test_backpressure();
      set_polyphony(16);
      pacing_on   = 1'b0;
      hold_cycles = HOLD_OFF;
      repeat (30) random_event();
      settle();
   endtask

   task automatic test_random_traffic();
      int count;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       count = 1;
            1:       count = 31;
            2:       count = 0;
            3:       count = 16;
            default: count = $urandom_range(0, 31);
         endcase
         set_polyphony(count);
         pacing_on    = (phase % 4) != 0;
         stall_enable = (phase % 3) != 0;
         burst_left   = 0;
         repeat (PHASE_WORDS) random_event();
      end
      settle();
   endtask

   initial begin : receiver
      int run_left;
      bit level;
      run_left  = 0;
      level     = 1'b1;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles - 1) @(posedge clock);
            hold_cycles = 0;
            run_left    = 0;
         end else begin
            if (run_left == 0) begin
               level    = stall_enable ? ~level : 1'b1;
               run_left = level ? $urandom_range(1, 24) : $urandom_range(1, 8);
            end
            run_left--;
            rsp_ready <= level;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_queue.size() == 0) begin
            $error("unexpected result word: granted_voice %0d was_stolen %0d",
                   rsp_payload.granted_voice, rsp_payload.was_stolen);
            errors++;
         end else begin
            oldest_grant = grant_queue[0];
            grant_queue.delete(0);
            if (rsp_payload.granted_voice !== oldest_grant.granted_voice) begin
               $error("granted_voice: expected %0d, actual %0d",
                      oldest_grant.granted_voice, rsp_payload.granted_voice);
               errors++;
            end
            if (rsp_payload.was_stolen !== oldest_grant.was_stolen) begin
               $error("was_stolen: expected %0d, actual %0d",
                      oldest_grant.was_stolen, rsp_payload.was_stolen);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      errors          = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      pacing_on       = 1'b0;
      stall_enable    = 1'b0;
      hold_cycles     = 0;
      voice_busy_mask = '0;
      polyphony       = VOICE_COUNT_RESET;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_steal();
      test_finish_events();
      test_count_limits();
      test_backpressure();
      test_random_traffic();

      if (grant_queue.size() != 0) begin
         $error("%0d expected result words never arrived", grant_queue.size());
         errors++;
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
